### rtl/dgs_pkg.sv
package dgs_pkg;

	localparam int SCORE_W   = 64;
	localparam int TERM_W    = 50;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	localparam logic [1:0] MODE_WEIGHTED   = 2'd0;
	localparam logic [1:0] MODE_LIKELIHOOD = 2'd1;
	localparam logic [1:0] MODE_EUCLID     = 2'd2;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_OBSERVE = 1'b1;

	localparam logic [1:0] CFG_MODE  = 2'd0;
	localparam logic [1:0] CFG_DET   = 2'd1;
	localparam logic [1:0] CFG_LOG   = 2'd2;
	localparam logic [1:0] CFG_COUNT = 2'd3;

	typedef struct packed {
		logic signed [TERM_W-1:0] term;
		logic                     last;
		logic [1:0]               mode;
	} mid_word_t;

	typedef struct packed {
		logic signed [31:0] det;
		logic signed [31:0] log_cnt;
		logic [15:0]        obs_cnt;
	} cfg_t;

endpackage

### rtl/dgs_fifo.sv
module dgs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/dgs_front.sv
module dgs_front #(
	parameter int DIMENSIONS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                operation,
	input  logic [5:0]          dimension,
	input  logic signed [15:0]  sample,
	input  logic signed [15:0]  inverse_variance,
	input  logic                final_element,
	input  logic [1:0]          score_mode,
	input  logic                mid_full,
	output logic                mid_push,
	output dgs_pkg::mid_word_t  mid_word
);

	localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

	logic signed [15:0] mean_mem [DIMENSIONS];
	logic signed [15:0] wt_mem [DIMENSIONS];

	logic          adv;
	logic          take;
	logic          in_range;
	logic [AW-1:0] addr;

	logic               v_s1;
	logic signed [15:0] sample_s1;
	logic signed [15:0] mean_s1;
	logic signed [15:0] wt_s1;
	logic               last_s1;
	logic               inr_s1;
	logic [1:0]         mode_s1;

	logic signed [16:0] diff;

	logic               v_s2;
	logic signed [33:0] sq_s2;
	logic signed [15:0] wt_s2;
	logic               last_s2;
	logic               inr_s2;
	logic [1:0]         mode_s2;

	logic signed [dgs_pkg::TERM_W-1:0] prod;
	logic signed [dgs_pkg::TERM_W-1:0] term;

	logic                              v_s3;
	logic signed [dgs_pkg::TERM_W-1:0] term_s3;
	logic                              last_s3;
	logic [1:0]                        mode_s3;

	// whole pipeline holds while the last stage waits on the queue
	assign adv      = !(v_s3 && mid_full);
	assign full     = !adv;
	assign take     = push && adv;
	assign in_range = (32'(dimension) < 32'(DIMENSIONS));
	assign addr     = AW'(dimension);

	always_ff @(posedge clk) begin
		if (take && operation == dgs_pkg::OP_WRITE && in_range) begin
			mean_mem[addr] <= sample;
			wt_mem[addr]   <= inverse_variance;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mean_s1   <= mean_mem[addr];
			wt_s1     <= wt_mem[addr];
			sample_s1 <= sample;
			last_s1   <= final_element;
			inr_s1    <= in_range;
			mode_s1   <= score_mode;
		end
	end

	assign diff = 17'(sample_s1) - 17'(mean_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2   <= 34'(diff) * 34'(diff);
			wt_s2   <= wt_s1;
			last_s2 <= last_s1;
			inr_s2  <= inr_s1;
			mode_s2 <= mode_s1;
		end
	end

	assign prod = sq_s2 * wt_s2;

	always_comb begin
		if (!inr_s2) begin
			term = '0;
		end else if (mode_s2 == dgs_pkg::MODE_EUCLID) begin
			term = dgs_pkg::TERM_W'(sq_s2) <<< 8;
		end else begin
			term = prod;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s3 <= term;
			last_s3 <= last_s2;
			mode_s3 <= mode_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take && operation == dgs_pkg::OP_OBSERVE;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign mid_push      = v_s3 && !mid_full;
	assign mid_word.term = term_s3;
	assign mid_word.last = last_s3;
	assign mid_word.mode = mode_s3;

endmodule

### rtl/dgs_back.sv
module dgs_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dgs_pkg::cfg_t                         cfg,
	input  logic                                  mid_empty,
	input  dgs_pkg::mid_word_t                    mid_word,
	output logic                                  mid_pop,
	input  logic [dgs_pkg::OUT_CW-1:0]            out_count,
	output logic                                  out_push,
	output logic signed [dgs_pkg::SCORE_W-1:0]    out_score
);

	localparam int SW = dgs_pkg::SCORE_W;
	localparam int RW = dgs_pkg::OUT_CW + 1;

	logic signed [SW-1:0] acc_q;
	logic signed [SW:0]   wide;
	logic signed [SW-1:0] sat;
	logic                 room;

	logic                 fin_v_s1;
	logic signed [SW-1:0] sum_s1;
	logic [1:0]           mode_s1;

	// a final term needs a result slot that no earlier final has claimed
	assign room    = (RW'(out_count) + RW'(fin_v_s1)) < RW'(dgs_pkg::OUT_DEPTH);
	assign mid_pop = !mid_empty && (!mid_word.last || room);

	assign wide = (SW + 1)'(acc_q) + (SW + 1)'(mid_word.term);

	always_comb begin
		if (wide[SW] != wide[SW-1]) begin
			sat = wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			sat = wide[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			fin_v_s1 <= 1'b0;
		end else begin
			fin_v_s1 <= mid_pop && mid_word.last;
			if (mid_pop) begin
				acc_q <= mid_word.last ? '0 : sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop && mid_word.last) begin
			sum_s1  <= sat;
			mode_s1 <= mid_word.mode;
		end
	end

	always_comb begin
		if (mode_s1 == dgs_pkg::MODE_LIKELIHOOD) begin
			out_score = (sum_s1 >>> 1) + SW'(cfg.det)
				- ((cfg.obs_cnt > 16'd1) ? SW'(cfg.log_cnt) : SW'(0));
		end else begin
			out_score = sum_s1;
		end
	end

	assign out_push = fin_v_s1;

endmodule

### rtl/diagonal_gaussian_score.sv
// Scores observation vectors against a diagonal Gaussian model held in two
// on-chip tables of DIMENSIONS entries (mean and inverse variance). Push model
// writes and observation elements through the input queue interface; every
// observation element marked final yields one 64-bit Q.8 score on the result
// queue. The block sustains one item per clock while full is low: each table
// has a single port read once per item, and the square and weight multiplies
// are split over three front stages, while the back end folds one queued term
// per clock into the saturating accumulator unless a final term waits for a
// result slot. A four-entry term queue decouples the two halves, so full rises
// only after the result queue has filled and the term queue behind it as well.
// Program the registers only while idle.
module diagonal_gaussian_score #(
	parameter int DIMENSIONS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               operation,
	input  logic [5:0]         dimension,
	input  logic signed [15:0] sample,
	input  logic signed [15:0] inverse_variance,
	input  logic               final_element,
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] score,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data
);

	localparam int MID_W = $bits(dgs_pkg::mid_word_t);

	logic [1:0]    mode_q;
	dgs_pkg::cfg_t cfg_q;

	logic               mid_push;
	logic               mid_full;
	logic               mid_empty;
	logic               mid_pop;
	dgs_pkg::mid_word_t mid_in;
	dgs_pkg::mid_word_t mid_out;
	logic [MID_W-1:0]   mid_rdata;
	logic [$clog2(dgs_pkg::MID_DEPTH+1)-1:0] mid_count;

	logic                              out_push;
	logic                              out_full;
	logic signed [dgs_pkg::SCORE_W-1:0] out_score;
	logic [dgs_pkg::OUT_CW-1:0]        out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= dgs_pkg::MODE_WEIGHTED;
			cfg_q.det     <= '0;
			cfg_q.log_cnt <= '0;
			cfg_q.obs_cnt <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				dgs_pkg::CFG_MODE:  mode_q        <= wr_data[1:0];
				dgs_pkg::CFG_DET:   cfg_q.det     <= wr_data;
				dgs_pkg::CFG_LOG:   cfg_q.log_cnt <= wr_data;
				dgs_pkg::CFG_COUNT: cfg_q.obs_cnt <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	dgs_front #(
		.DIMENSIONS(DIMENSIONS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.operation        (operation),
		.dimension        (dimension),
		.sample           (sample),
		.inverse_variance (inverse_variance),
		.final_element    (final_element),
		.score_mode       (mode_q),
		.mid_full         (mid_full),
		.mid_push         (mid_push),
		.mid_word         (mid_in)
	);

	dgs_fifo #(
		.WIDTH(MID_W),
		.DEPTH(dgs_pkg::MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	assign mid_out = mid_rdata;

	dgs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_word  (mid_out),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_score (out_score)
	);

	dgs_fifo #(
		.WIDTH(dgs_pkg::SCORE_W),
		.DEPTH(dgs_pkg::OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_score),
		.full   (out_full),
		.pop    (pop),
		.rdata  (score),
		.empty  (empty),
		.count  (out_count)
	);

	// out_full never blocks a push: the back end reserves a slot first
	logic unused_ok;
	assign unused_ok = out_full ^ (mid_count == '0);

endmodule

### rtl/dgs_checker.sv
module dgs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [63:0] score
);

	// queues come out of reset empty: nothing to deliver right after reset
	a_empty_after_reset: assert property (@(posedge clk)
		!arst_n |=> empty)
		else $error("result queue not empty after reset");

	a_not_full_in_reset: assert property (@(posedge clk)
		!arst_n |=> !full)
		else $error("input reports full during reset");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(score)))
		else $error("waiting result changed or vanished");

	// full needs the result side backed up: a full term queue behind a full
	// result queue
	a_full_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input stalled with no result waiting");

endmodule

bind diagonal_gaussian_score dgs_checker u_dgs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.score  (score)
);
